/* rtl/core/sqrtb_pkg.sv */
// ----------------------------------------------------------------------------
// sqrtb_pkg
// shared types and constants for the bisection square root block
// ----------------------------------------------------------------------------
package sqrtb_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned StepsW = 7;
  localparam int unsigned FracW  = 16;
  localparam int unsigned WideW  = DataW + FracW;  // q16.32 view of a q16.16 value
  localparam int unsigned SqW    = 2 * DataW;

  // 1.0 in q16.16
  localparam logic [DataW-1:0] OneQ16 = 32'h0001_0000;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SQ   = 4'b0010,
    ST_CHK  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

endpackage

/* rtl/core/sqrtb_if.sv */
// ----------------------------------------------------------------------------
// sqrtb_in_if / sqrtb_out_if
// valid/ready channels carrying the radicand in and the root result out
// ----------------------------------------------------------------------------
interface sqrtb_in_if import sqrtb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] radicand;

  modport source (output valid, output radicand, input ready);
  modport sink (input valid, input radicand, output ready);
endinterface

interface sqrtb_out_if import sqrtb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DataW-1:0]  root;
  logic [StepsW-1:0] steps;
  logic              converged;

  modport source (output valid, output root, output steps, output converged, input ready);
  modport sink (input valid, input root, input steps, input converged, output ready);
endinterface

/* rtl/core/square_root_bisection.sv */
// ----------------------------------------------------------------------------
// square_root_bisection
// square root of an unsigned q16.16 value by bisection, one item at a time
// ----------------------------------------------------------------------------
// The block takes one unsigned q16.16 radicand per item and returns one result
// item: the final midpoint as a q16.16 root, the number of halvings done and a
// converged flag. The search interval starts at [0, max(1.0, radicand)]; each
// midpoint is squared exactly (q32.32) and the search stops once the squared
// error is within epsilon (shifted to q32.32), when a halving no longer moves
// the midpoint, or after MAX_ITER halvings; the last two clear converged.
// A radicand of 0 or 1.0 comes straight back with steps 0 and converged set.
// One 32x32 multiplier is shared by every halving: each midpoint is squared in
// ST_SQ, then compared and stepped in ST_CHK. The input is ready only while the
// block is idle; a finished result sits in an output register until taken, and
// the next item may be accepted while that result still waits there.
// epsilon is written through cfg_wr_en / cfg_wr_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module square_root_bisection
  import sqrtb_pkg::*;
#(
  parameter int unsigned MAX_ITER = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  sqrtb_in_if.sink          in_ch,
  sqrtb_out_if.source       out_ch,
  input  logic              cfg_wr_en,
  input  logic [DataW-1:0]  cfg_wr_data
);

  localparam logic [StepsW-1:0] MaxIterC = StepsW'(MAX_ITER);

  // control
  state_t            state_r, state_nxt;
  logic [StepsW-1:0] count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;

  // configuration
  logic [DataW-1:0]  epsilon_r;

  // search datapath
  logic [DataW-1:0]  rad_r, rad_nxt;
  logic [DataW-1:0]  lo_r, lo_nxt;
  logic [DataW-1:0]  hi_r, hi_nxt;
  logic [DataW-1:0]  x_r, x_nxt;
  logic [SqW-1:0]    sq_r;
  logic [WideW:0]    ubnd_r, ubnd_nxt;   // target + tol
  logic [WideW-1:0]  lbnd_r, lbnd_nxt;   // target - tol, floored at zero
  logic              conv_r, conv_nxt;

  // output register
  logic [DataW-1:0]  out_root_r;
  logic [StepsW-1:0] out_steps_r;
  logic              out_conv_r;

  // accept-time values
  logic              in_acc;
  logic [WideW-1:0]  in_target;
  logic [WideW-1:0]  in_tol;
  logic [WideW:0]    in_diff;
  logic              in_special;
  logic [DataW-1:0]  in_hi;

  // compare/step values
  logic [WideW-1:0]  target;
  logic              tol_met;
  logic              below;
  logic [DataW:0]    sum_up;
  logic [DataW:0]    sum_dn;
  logic [DataW-1:0]  mid_nxt;
  logic              out_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign in_target  = {in_ch.radicand, {FracW{1'b0}}};
  assign in_tol     = {epsilon_r, {FracW{1'b0}}};
  assign in_diff    = {1'b0, in_target} - {1'b0, in_tol};
  assign in_special = (in_ch.radicand == '0) || (in_ch.radicand == OneQ16);
  assign in_hi      = (in_ch.radicand > OneQ16) ? in_ch.radicand : OneQ16;

  // tolerance test as a window on the square, plus direction of the step
  assign target  = {rad_r, {FracW{1'b0}}};
  assign tol_met = (sq_r >= SqW'(lbnd_r)) && (sq_r <= SqW'(ubnd_r));
  assign below   = (sq_r < SqW'(target));
  // both candidate midpoints formed alongside the compare
  assign sum_up  = {1'b0, x_r} + {1'b0, hi_r};
  assign sum_dn  = {1'b0, lo_r} + {1'b0, x_r};
  assign mid_nxt = below ? sum_up[DataW:1] : sum_dn[DataW:1];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    rad_nxt       = rad_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    x_nxt         = x_r;
    ubnd_nxt      = ubnd_r;
    lbnd_nxt      = lbnd_r;
    conv_nxt      = conv_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rad_nxt   = in_ch.radicand;
          lo_nxt    = '0;
          hi_nxt    = in_hi;
          count_nxt = '0;
          ubnd_nxt  = {1'b0, in_target} + {1'b0, in_tol};
          lbnd_nxt  = in_diff[WideW] ? '0 : in_diff[WideW-1:0];
          if (in_special) begin
            // zero and one are their own roots
            x_nxt     = in_ch.radicand;
            conv_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            x_nxt     = in_hi >> 1;
            state_nxt = ST_SQ;
          end
        end
      end
      ST_SQ: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (tol_met) begin
          conv_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else if (count_r >= MaxIterC) begin
          conv_nxt  = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          if (below) begin
            lo_nxt = x_r;
          end else begin
            hi_nxt = x_r;
          end
          count_nxt = count_r + 1'b1;
          if (mid_nxt == x_r) begin
            // interval has collapsed, midpoint stuck
            conv_nxt  = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            x_nxt     = mid_nxt;
            state_nxt = ST_SQ;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      epsilon_r   <= 32'd66;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        epsilon_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    x_r    <= x_nxt;
    ubnd_r <= ubnd_nxt;
    lbnd_r <= lbnd_nxt;
    conv_r <= conv_nxt;
    // shared squarer
    if (state_r == ST_SQ) begin
      sq_r <= x_r * x_r;
    end
    if (state_r == ST_DONE && out_free) begin
      out_root_r  <= x_r;
      out_steps_r <= count_r;
      out_conv_r  <= conv_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.root      = out_root_r;
  assign out_ch.steps     = out_steps_r;
  assign out_ch.converged = out_conv_r;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MaxIterC)
    else $error("halving count past cap");

  a_mid_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQ) |-> (lo_r <= x_r) && (x_r <= hi_r))
    else $error("midpoint outside search interval");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside done state");

  a_fail_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_conv_r) |-> (out_steps_r != '0))
    else $error("unconverged result with no halvings");

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input ready straight after acceptance");
`endif

endmodule
